/* sv/cmos_rtc_index_data_port_defines.svh */
// assertion macros used by the cmos rtc controller
// expects clk and rst_n in scope at the point of use
`ifndef CMOS_RTC_INDEX_DATA_PORT_DEFINES_SVH
`define CMOS_RTC_INDEX_DATA_PORT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CMOSRTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CMOSRTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/cmosrtc_pkg.sv */
// types, codes and helpers for the cmos rtc index/data port block
// no dependencies
package cmosrtc_pkg;

    typedef struct packed {
        logic [1:0] opcode;
        logic       port;
        logic [7:0] write_data;
        logic [5:0] now_seconds;
        logic [5:0] now_minutes;
        logic [4:0] now_hours;
        logic [2:0] now_weekday;
        logic [4:0] now_day;
        logic [3:0] now_month;
        logic [6:0] now_year;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_pulse;
    } rsp_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic access;
        logic result;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_RESULT,
        ST_SEND
    } state_t;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic PORT_INDEX = 1'b0;
    localparam logic PORT_DATA  = 1'b1;

    localparam logic [7:0] IDX_SECONDS = 8'h00;
    localparam logic [7:0] IDX_MINUTES = 8'h02;
    localparam logic [7:0] IDX_HOURS   = 8'h04;
    localparam logic [7:0] IDX_WEEKDAY = 8'h06;
    localparam logic [7:0] IDX_DAY     = 8'h07;
    localparam logic [7:0] IDX_MONTH   = 8'h08;
    localparam logic [7:0] IDX_YEAR    = 8'h09;
    localparam logic [7:0] IDX_REG_B   = 8'h0B;

    localparam int PIE_BIT = 6;

    // packed bcd of a value below 128: tens by reciprocal multiply, result kept to 8 bits
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [3:0]  ones;
        prod = 15'(v) * 15'd205;
        tens = prod[14:11];
        ones = 4'(v - 7'(7'(tens) * 7'd10));
        return {tens, 4'b0000} + {4'b0000, ones};
    endfunction

endpackage

/* sv/cmosrtc_ctrl.sv */
// controller state machine for the cmos rtc block
// depends on cmosrtc_pkg and cmos_rtc_index_data_port_defines.svh
`include "cmos_rtc_index_data_port_defines.svh"

module cmosrtc_ctrl
    import cmosrtc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    output logic rsp_valid,
    input  logic rsp_stall,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS: state_next = ST_RESULT;
            ST_RESULT: state_next = ST_SEND;
            ST_SEND:
            begin
                if (!rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_stall   = 1'b1;
        rsp_valid   = 1'b0;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.capture = req_valid;
            end
            ST_ACCESS: cmd.access = 1'b1;
            ST_RESULT: cmd.result = 1'b1;
            ST_SEND:   rsp_valid  = 1'b1;
            default:   req_stall  = 1'b1;
        endcase
    end

    `CMOSRTC_ASSERT_NEXT(a_access_after_accept, req_valid && !req_stall, cmd.access, "no access after accept")
    `CMOSRTC_ASSERT_NOW(a_busy_while_result, rsp_valid, req_stall, "request taken while result pending")
    `CMOSRTC_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0({cmd.capture, cmd.access, cmd.result}), "overlapping commands")
    `CMOSRTC_ASSERT_NEXT(a_result_then_send, cmd.result, rsp_valid, "result not presented")

endmodule

/* sv/cmosrtc_dp.sv */
// datapath for the cmos rtc block: index register, cmos ram, interrupt enable, result register
// depends on cmosrtc_pkg
module cmosrtc_dp
    import cmosrtc_pkg::*;
#(
    parameter int RAM_DEPTH = 256
)
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  req_t req,
    output rsp_t rsp
);

    localparam int AW = $clog2(RAM_DEPTH);

    req_t                 item_reg;
    logic [7:0]           index_reg;
    logic                 pie_reg;
    logic [RAM_DEPTH-1:0] valid_reg;
    logic [7:0]           ram [RAM_DEPTH];
    logic [7:0]           ram_q_reg;
    logic                 hit_reg;
    rsp_t                 rsp_reg;
    rsp_t                 rsp_next;

    logic [AW-1:0]        addr;
    logic                 in_range;
    logic                 data_write;
    logic [7:0]           data_read;

    assign addr       = index_reg[AW-1:0];
    assign in_range   = ({1'b0, index_reg} < 9'(RAM_DEPTH));
    assign data_write = cmd.access && (item_reg.opcode == OP_WRITE)
                        && (item_reg.port == PORT_DATA);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= req;
        end
    end

    // control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= '0;
            pie_reg   <= 1'b0;
            valid_reg <= '0;
        end
        else if (cmd.access && item_reg.opcode == OP_WRITE)
        begin
            if (item_reg.port == PORT_INDEX)
            begin
                index_reg <= item_reg.write_data;
            end
            else
            begin
                if (in_range)
                begin
                    valid_reg[addr] <= 1'b1;
                end
                if (index_reg == IDX_REG_B)
                begin
                    pie_reg <= item_reg.write_data[PIE_BIT];
                end
            end
        end
    end

    // cmos ram, entries read as zero until first written
    always_ff @(posedge clk)
    begin
        if (data_write && in_range)
        begin
            ram[addr] <= item_reg.write_data;
        end
        if (cmd.access)
        begin
            ram_q_reg <= ram[addr];
            hit_reg   <= in_range && valid_reg[addr];
        end
    end

    always_comb
    begin
        case (index_reg)
            IDX_SECONDS: data_read = to_bcd({1'b0, item_reg.now_seconds});
            IDX_MINUTES: data_read = to_bcd({1'b0, item_reg.now_minutes});
            IDX_HOURS:   data_read = to_bcd({2'b00, item_reg.now_hours});
            IDX_WEEKDAY: data_read = {5'b00000, item_reg.now_weekday};
            IDX_DAY:     data_read = to_bcd({2'b00, item_reg.now_day});
            IDX_MONTH:   data_read = to_bcd({3'b000, item_reg.now_month});
            IDX_YEAR:    data_read = to_bcd(item_reg.now_year);
            default:     data_read = hit_reg ? ram_q_reg : 8'h00;
        endcase
    end

    always_comb
    begin
        rsp_next = '0;
        case (item_reg.opcode)
            OP_READ:
            begin
                rsp_next.read_data = (item_reg.port == PORT_INDEX) ? index_reg : data_read;
            end
            OP_TICK:  rsp_next.irq_pulse = pie_reg;
            default:  rsp_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

/* sv/cmos_rtc_index_data_port.sv */
// cmos rtc index/data port: one request in, one response out. a request is
// taken only while the block is idle; it is then captured, goes through the ram
// access (index or byte write, registered ram read) and then through forming the
// response, and the response is shown from its output register until
// the receiver takes it, after which the next request can be taken. the registered read port
// of the cmos ram sets the access cycle. port 0 holds the 8-bit index, port 1 reads or writes
// the byte at that index; indices 0, 2, 4, 7, 8 and 9 read back seconds, minutes, hours, day,
// month and year in bcd from the request's time fields, index 6 the weekday in binary, and
// any other index the ram byte (zero at or beyond RAM_DEPTH). a data write at index 0x0b
// loads the periodic interrupt enable from bit 6, and a tick request answers with irq_pulse
// set while that enable is on. ram contents read as zero after reset through per-entry valid
// bits, so no clearing pass is needed and requests are taken right out of reset.
// depends on cmosrtc_pkg, cmosrtc_ctrl and cmosrtc_dp
module cmos_rtc_index_data_port
    import cmosrtc_pkg::*;
#(
    parameter int RAM_DEPTH = 256
)
(
    input  logic clk,
    input  logic rst_n,
    // request channel
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    // response channel
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    // command bundle from sequencer to datapath
    cmd_t cmd;

    // sequencer: idle, access, result, send
    cmosrtc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    // index register, ram, interrupt enable and response register
    cmosrtc_dp #(
        .RAM_DEPTH (RAM_DEPTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

/* tb/tb_cmos_rtc_index_data_port.sv */
// self-checking testbench for the cmos rtc index/data port block
// tracks index, ram and interrupt enable in its own shadow copy; needs cmosrtc_pkg and the rtl
module tb_cmos_rtc_index_data_port
    import cmosrtc_pkg::*;
();

    localparam int CMOS_DEPTH   = 256;
    localparam int RANDOM_ITEMS = 990;
    localparam int LONG_HOLD    = 300;   // receiver hold-off, long enough to back up the request side
    localparam int QUIET_LIMIT  = 3000;  // cycles with no transfer on either channel before giving up
    localparam int DRAIN_CYCLES = 12;    // settle time after the last response

    // opcode that the block must treat as a no-op
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // requests waiting to be driven, responses predicted but not yet seen
    req_t pending_req_q[$];
    rsp_t expected_rsp_q[$];

    // shadow of the block's state
    logic [7:0] cur_index = 8'h00;
    logic [7:0] cmos_shadow [CMOS_DEPTH] = '{default: 8'h00};
    logic       periodic_on = 1'b0;

    // idle rates in percent, switched per phase by the stimulus process
    int unsigned send_idle_pct = 0;
    int unsigned rcv_idle_pct  = 0;

    // long hold-off requests from stimulus, served by the receiver process
    int unsigned hold_requests = 0;
    int unsigned holds_served  = 0;
    int unsigned hold_left     = 0;

    int unsigned mismatches = 0;

    cmos_rtc_index_data_port #(
        .RAM_DEPTH (CMOS_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // packed bcd of a time value, tens in the upper nibble, kept to 8 bits
    function automatic logic [7:0] bcd_of(input int unsigned v);
        return 8'(((v / 10) * 16) + (v % 10));
    endfunction

    // expected response for one request; advances the shadow state
    function automatic rsp_t predict_response(input req_t r);
        rsp_t res;
        res = '0;
        case (r.opcode)
            OP_READ:
            begin
                if (r.port == PORT_INDEX)
                    res.read_data = cur_index;
                else
                begin
                    // clock indices override the ram, even after a data write there
                    case (cur_index)
                        IDX_SECONDS: res.read_data = bcd_of(32'(r.now_seconds));
                        IDX_MINUTES: res.read_data = bcd_of(32'(r.now_minutes));
                        IDX_HOURS:   res.read_data = bcd_of(32'(r.now_hours));
                        IDX_WEEKDAY: res.read_data = 8'(r.now_weekday);
                        IDX_DAY:     res.read_data = bcd_of(32'(r.now_day));
                        IDX_MONTH:   res.read_data = bcd_of(32'(r.now_month));
                        IDX_YEAR:    res.read_data = bcd_of(32'(r.now_year));
                        default:
                            res.read_data = (int'(cur_index) < CMOS_DEPTH) ?
                                            cmos_shadow[cur_index] : 8'h00;
                    endcase
                end
            end
            OP_WRITE:
            begin
                if (r.port == PORT_INDEX)
                    cur_index = r.write_data;
                else
                begin
                    if (int'(cur_index) < CMOS_DEPTH)
                        cmos_shadow[cur_index] = r.write_data;
                    // every register b write reloads the enable, so a zero bit stops ticks
                    if (cur_index == IDX_REG_B)
                        periodic_on = r.write_data[PIE_BIT];
                end
            end
            OP_TICK:
                res.irq_pulse = periodic_on;
            default: ;
        endcase
        return res;
    endfunction

    // request with random time fields; one in five uses unconstrained values that can be out of range
    function automatic req_t mk_req(input logic [1:0] op, input logic p, input logic [7:0] d);
        req_t r;
        r.opcode     = op;
        r.port       = p;
        r.write_data = d;
        if ($urandom_range(4) == 0)
        begin
            r.now_seconds = 6'($urandom);
            r.now_minutes = 6'($urandom);
            r.now_hours   = 5'($urandom);
            r.now_weekday = 3'($urandom);
            r.now_day     = 5'($urandom);
            r.now_month   = 4'($urandom);
            r.now_year    = 7'($urandom);
        end
        else
        begin
            r.now_seconds = 6'($urandom_range(59));
            r.now_minutes = 6'($urandom_range(59));
            r.now_hours   = 5'($urandom_range(23));
            r.now_weekday = 3'($urandom_range(6));
            r.now_day     = 5'($urandom_range(31, 1));
            r.now_month   = 4'($urandom_range(12, 1));
            r.now_year    = 7'($urandom_range(99));
        end
        return r;
    endfunction

    // index choice leaning toward the clock registers and register b
    function automatic logic [7:0] pick_index();
        case ($urandom_range(7))
            0: return IDX_SECONDS;
            1: return IDX_MINUTES;
            2: return IDX_HOURS;
            3: return IDX_WEEKDAY;
            4: return ($urandom_range(1) != 0) ? IDX_DAY : IDX_MONTH;
            5: return ($urandom_range(1) != 0) ? IDX_YEAR : IDX_REG_B;
            6: return 8'($urandom_range(31));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // edge values of several time fields, every opcode and the named corner cases
    task automatic queue_directed();
        req_t r;
        // index port read straight out of reset
        pending_req_q.push_back(mk_req(OP_READ, PORT_INDEX, 8'h00));
        // tick with the interrupt still disabled
        pending_req_q.push_back(mk_req(OP_TICK, PORT_INDEX, 8'h00));
        pending_req_q.push_back(mk_req(OP_WRITE, PORT_INDEX, IDX_SECONDS));
        r = mk_req(OP_READ, PORT_DATA, 8'h00);
        r.now_seconds = 6'd59;
        pending_req_q.push_back(r);
        // out-of-range seconds still split by ten
        r.now_seconds = 6'd63;
        pending_req_q.push_back(r);
        pending_req_q.push_back(mk_req(OP_WRITE, PORT_INDEX, IDX_HOURS));
        r = mk_req(OP_READ, PORT_DATA, 8'h00);
        r.now_hours = 5'd31;
        pending_req_q.push_back(r);
        pending_req_q.push_back(mk_req(OP_WRITE, PORT_INDEX, IDX_WEEKDAY));
        r = mk_req(OP_READ, PORT_DATA, 8'h00);
        r.now_weekday = 3'd7;
        pending_req_q.push_back(r);
        // month ones digit must come through for 10..12
        pending_req_q.push_back(mk_req(OP_WRITE, PORT_INDEX, IDX_MONTH));
        r = mk_req(OP_READ, PORT_DATA, 8'h00);
        r.now_month = 4'd12;
        pending_req_q.push_back(r);
        r.now_month = 4'd15;
        pending_req_q.push_back(r);
        // a data write at a clock index lands in ram but reads stay on the clock
        pending_req_q.push_back(mk_req(OP_WRITE, PORT_INDEX, IDX_YEAR));
        pending_req_q.push_back(mk_req(OP_WRITE, PORT_DATA, 8'hA5));
        r = mk_req(OP_READ, PORT_DATA, 8'h00);
        r.now_year = 7'd127;
        pending_req_q.push_back(r);
        // enable the periodic interrupt, tick, then clear the bit and tick again
        pending_req_q.push_back(mk_req(OP_WRITE, PORT_INDEX, IDX_REG_B));
        pending_req_q.push_back(mk_req(OP_WRITE, PORT_DATA, 8'hFF));
        pending_req_q.push_back(mk_req(OP_TICK, PORT_DATA, 8'h00));
        pending_req_q.push_back(mk_req(OP_WRITE, PORT_DATA, 8'hBF));
        pending_req_q.push_back(mk_req(OP_TICK, PORT_DATA, 8'h00));
        // top of the ram and the index port read back
        pending_req_q.push_back(mk_req(OP_WRITE, PORT_INDEX, 8'hFF));
        pending_req_q.push_back(mk_req(OP_WRITE, PORT_DATA, 8'h00));
        pending_req_q.push_back(mk_req(OP_READ, PORT_DATA, 8'h00));
        pending_req_q.push_back(mk_req(OP_READ, PORT_INDEX, 8'h00));
        // unused opcode does nothing
        pending_req_q.push_back(mk_req(OP_UNUSED, PORT_DATA, 8'hFF));
    endtask

    // mostly index-then-data sequences, some register b and tick runs, some raw noise
    task automatic queue_random(input int n);
        int   queued;
        int   kind;
        int   reps;
        logic [63:0] noise;
        queued = 0;
        while (queued < n)
        begin
            kind = $urandom_range(99);
            if (kind < 40)
            begin
                pending_req_q.push_back(mk_req(OP_WRITE, PORT_INDEX, pick_index()));
                reps = $urandom_range(3, 1);
                repeat (reps)
                    pending_req_q.push_back(mk_req(OP_READ, PORT_DATA, 8'($urandom)));
                if ($urandom_range(3) == 0)
                begin
                    pending_req_q.push_back(mk_req(OP_READ, PORT_INDEX, 8'($urandom)));
                    reps++;
                end
                queued += reps + 1;
            end
            else if (kind < 60)
            begin
                pending_req_q.push_back(mk_req(OP_WRITE, PORT_INDEX, pick_index()));
                pending_req_q.push_back(mk_req(OP_WRITE, PORT_DATA, 8'($urandom)));
                pending_req_q.push_back(mk_req(OP_READ, PORT_DATA, 8'($urandom)));
                queued += 3;
            end
            else if (kind < 75)
            begin
                pending_req_q.push_back(mk_req(OP_WRITE, PORT_INDEX, IDX_REG_B));
                pending_req_q.push_back(mk_req(OP_WRITE, PORT_DATA, 8'($urandom)));
                reps = $urandom_range(2, 1);
                repeat (reps)
                    pending_req_q.push_back(mk_req(OP_TICK, 1'($urandom), 8'($urandom)));
                queued += reps + 2;
            end
            else if (kind < 85)
            begin
                pending_req_q.push_back(mk_req(OP_TICK, 1'($urandom), 8'($urandom)));
                queued++;
            end
            else
            begin
                // all fields random, unused opcode included
                noise = {$urandom, $urandom};
                pending_req_q.push_back(noise[$bits(req_t)-1:0]);
                queued++;
            end
        end
    endtask

    // sender pauses until every predicted response has come back
    task automatic wait_drained();
        while (pending_req_q.size() != 0 || req_valid || expected_rsp_q.size() != 0)
            @(negedge clk);
    endtask

    // request driver: a new payload goes out only when the current one has transferred
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
                expected_rsp_q.push_back(predict_response(req));
            if (!req_valid || !req_stall)
            begin
                if (pending_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_valid <= 1'b1;
                    req       <= pending_req_q.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // response side stall: random per cycle, or a long hold-off when stimulus asks for one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (holds_served != hold_requests)
        begin
            rsp_stall    <= 1'b1;
            hold_left    <= LONG_HOLD;
            holds_served <= holds_served + 1;
        end
        else
            rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    // response monitor: each transfer is checked against the oldest prediction
    always @(posedge clk)
    begin : check_rsp
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                $error("response with nothing expected: read_data %0h irq_pulse %0b",
                       rsp.read_data, rsp.irq_pulse);
                mismatches++;
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                if (rsp.read_data !== want.read_data)
                begin
                    $error("read_data expected %0h actual %0h", want.read_data, rsp.read_data);
                    mismatches++;
                end
                if (rsp.irq_pulse !== want.irq_pulse)
                begin
                    $error("irq_pulse expected %0b actual %0b", want.irq_pulse, rsp.irq_pulse);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: ends the run if no transfer happens on either channel for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // stimulus: reset, directed items, then three random phases with different idling
    initial
    begin : stimulus
        int ph;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_directed();
        wait_drained();

        for (ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 23;
                    rcv_idle_pct  = 83;
                end
                1:
                begin
                    send_idle_pct = 83;
                    rcv_idle_pct  = 23;
                end
                default:
                begin
                    send_idle_pct = 0;
                    rcv_idle_pct  = 0;
                end
            endcase
            queue_random(RANDOM_ITEMS / 3);
            // with no idling, hold the receiver off while the sender keeps offering
            if (ph == 2)
                hold_requests++;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && expected_rsp_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/cmosrtc_pkg.sv
sv/cmosrtc_ctrl.sv
sv/cmosrtc_dp.sv
sv/cmos_rtc_index_data_port.sv
tb/tb_cmos_rtc_index_data_port.sv
